>>> hdl/dpb_pkg.sv
// dpb_pkg: shared types and constants of the depth pixel back-projection block
// register indexes, reset values, field widths, control structs
// no dependencies
`default_nettype none
package dpb_pkg;

    // field widths
    localparam int DIM_W      = 13;
    localparam int Q4_W       = 16;
    localparam int INV_W      = 24;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int POINT_W    = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    // product carries 28 fraction bits (Q4 offset times Q24 reciprocal)
    localparam int ROUND_SHIFT = 28;
    localparam logic [ROUND_SHIFT-1:0] ROUND_HALF = 28'h8000000;

    localparam logic [POINT_W-1:0] SAT_POS     = 24'h7FFFFF;
    localparam logic [POINT_W-1:0] SAT_NEG     = 24'h800000;
    localparam logic [POINT_W:0]   SAT_NEG_MAG = 25'h0800000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X_Q4     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y_Q4     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X_Q24 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y_Q24 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DEPTH_MM    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH_MM    = 3'd7;

    // reset values
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [Q4_W-1:0]    RST_CENTER_X_Q4  = 16'd5120;
    localparam logic [Q4_W-1:0]    RST_CENTER_Y_Q4  = 16'd3840;
    localparam logic [INV_W-1:0]   RST_INV_FOCAL    = 24'd33554;
    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH_MM = 16'd10;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH_MM = 16'd10000;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [Q4_W-1:0]    center_x_q4;
        logic [Q4_W-1:0]    center_y_q4;
        logic [INV_W-1:0]   inv_focal_x_q24;
        logic [INV_W-1:0]   inv_focal_y_q24;
        logic [DEPTH_W-1:0] min_depth_mm;
        logic [DEPTH_W-1:0] max_depth_mm;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // input transfer: advance counters, latch operands
        logic mul1;      // offset times depth
        logic mul2;      // partial products with the reciprocal
        logic sum;       // combine partials, take rounded magnitude
        logic load_out;  // saturate and fill the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic keep;      // pixel at the head of the input is on the grid and in range
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/dpb_ctrl.sv
// dpb_ctrl: sequencer of the back-projection datapath and owner of both handshakes
// depends on dpb_pkg
`default_nettype none
module dpb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire dpb_pkg::stat_t stat,
    output dpb_pkg::cmd_t      cmd
);
    import dpb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && stat.keep) state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait here while the previous point is still not taken
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_keep_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && stat.keep) |=> (state_reg == S_MUL1))
        else $error("kept pixel did not start the datapath sequence");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("output register loaded over a point not yet transferred");

    a_mul2_after_mul1: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL2) |-> ($past(state_reg) == S_MUL1))
        else $error("second multiply step entered out of order");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result appeared without passing the output step");

endmodule
`default_nettype wire

>>> hdl/dpb_datapath.sv
// dpb_datapath: pixel counters, stride and depth test, fixed-point back-projection
// and the output register; stepped by dpb_ctrl; depends on dpb_pkg
`default_nettype none
module dpb_datapath #(
    parameter int PIXEL_STRIDE = 3,
    parameter int COORD_BITS   = 12
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dpb_pkg::cmd_t                  cmd,
    output dpb_pkg::stat_t                      stat,
    input  wire dpb_pkg::cfg_t                  cfg,
    input  wire logic [dpb_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic      [dpb_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dpb_pkg::*;

    localparam int SPW = (PIXEL_STRIDE > 1) ? $clog2(PIXEL_STRIDE) : 1;
    localparam int PW  = COORD_BITS + 4;
    localparam int OW  = (PW > Q4_W) ? PW : Q4_W;
    localparam int P1W = OW + DEPTH_W;
    localparam int LW  = (P1W + 1) / 2;
    localparam int HW  = P1W - LW;
    localparam int LOW = LW + INV_W + 1;
    localparam int HIW = HW + INV_W;
    localparam int FW  = P1W + INV_W + 1;
    localparam int MW  = FW - ROUND_SHIFT;
    localparam int CW  = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam logic [SPW-1:0] PH_LAST = SPW'(PIXEL_STRIDE - 1);

    // input fields
    logic [DEPTH_W-1:0] in_depth;
    logic [COLOR_W-1:0] in_blue, in_green, in_red;
    assign in_depth = s_tdata[15:0];
    assign in_blue  = s_tdata[23:16];
    assign in_green = s_tdata[31:24];
    assign in_red   = s_tdata[39:32];

    // raster position; phase counters track position modulo the stride
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [SPW-1:0]        col_ph_reg, row_ph_reg;
    logic [COORD_BITS:0]   col_inc, row_inc;
    logic                  col_wrap, row_wrap;

    assign col_inc  = {1'b0, col_reg} + (COORD_BITS+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (COORD_BITS+1)'(1);
    assign col_wrap = (CW'(col_inc) >= CW'(cfg.image_width)) || col_inc[COORD_BITS];
    assign row_wrap = (CW'(row_inc) >= CW'(cfg.image_height)) || row_inc[COORD_BITS];

    assign stat.keep = (col_ph_reg == '0) && (row_ph_reg == '0) &&
                       (in_depth >= cfg.min_depth_mm) && (in_depth <= cfg.max_depth_mm);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            col_ph_reg <= '0;
            row_ph_reg <= '0;
        end else if (cmd.capture) begin
            if (col_wrap) begin
                col_reg    <= '0;
                col_ph_reg <= '0;
                if (row_wrap) begin
                    row_reg    <= '0;
                    row_ph_reg <= '0;
                end else begin
                    row_reg    <= row_inc[COORD_BITS-1:0];
                    row_ph_reg <= (row_ph_reg == PH_LAST) ? '0 : row_ph_reg + SPW'(1);
                end
            end else begin
                col_reg    <= col_inc[COORD_BITS-1:0];
                col_ph_reg <= (col_ph_reg == PH_LAST) ? '0 : col_ph_reg + SPW'(1);
            end
        end
    end

    // signed Q4 offsets split into sign and magnitude
    logic [OW-1:0] pos_x, pos_y, cen_x, cen_y, off_x, off_y;
    logic          neg_x, neg_y;

    assign pos_x = OW'({col_reg, 4'b0000});
    assign pos_y = OW'({row_reg, 4'b0000});
    assign cen_x = OW'(cfg.center_x_q4);
    assign cen_y = OW'(cfg.center_y_q4);
    assign neg_x = cen_x > pos_x;
    assign neg_y = cen_y > pos_y;
    assign off_x = neg_x ? cen_x - pos_x : pos_x - cen_x;
    assign off_y = neg_y ? cen_y - pos_y : pos_y - cen_y;

    logic [OW-1:0]      off_x_reg, off_y_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COLOR_W-1:0] blue_reg, green_reg, red_reg;
    logic [P1W-1:0]     p1_x_reg, p1_y_reg;
    logic [LOW-1:0]     lo_x_reg, lo_y_reg;
    logic [HIW-1:0]     hi_x_reg, hi_y_reg;
    logic [FW-1:0]      full_x, full_y;
    logic [MW-1:0]      mag_x_reg, mag_y_reg;

    // rounding half rides in with the low partial product
    assign full_x = (FW'(hi_x_reg) << LW) + FW'(lo_x_reg);
    assign full_y = (FW'(hi_y_reg) << LW) + FW'(lo_y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            off_x_reg <= off_x;
            off_y_reg <= off_y;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            depth_reg <= in_depth;
            blue_reg  <= in_blue;
            green_reg <= in_green;
            red_reg   <= in_red;
        end
        if (cmd.mul1) begin
            p1_x_reg <= P1W'(off_x_reg) * P1W'(depth_reg);
            p1_y_reg <= P1W'(off_y_reg) * P1W'(depth_reg);
        end
        if (cmd.mul2) begin
            lo_x_reg <= LOW'(p1_x_reg[LW-1:0]) * LOW'(cfg.inv_focal_x_q24) + LOW'(ROUND_HALF);
            lo_y_reg <= LOW'(p1_y_reg[LW-1:0]) * LOW'(cfg.inv_focal_y_q24) + LOW'(ROUND_HALF);
            hi_x_reg <= HIW'(p1_x_reg[P1W-1:LW]) * HIW'(cfg.inv_focal_x_q24);
            hi_y_reg <= HIW'(p1_y_reg[P1W-1:LW]) * HIW'(cfg.inv_focal_y_q24);
        end
        if (cmd.sum) begin
            mag_x_reg <= full_x[FW-1:ROUND_SHIFT];
            mag_y_reg <= full_y[FW-1:ROUND_SHIFT];
        end
    end

    function automatic logic [POINT_W-1:0] sat_axis(input logic neg, input logic [MW-1:0] mag);
        logic [POINT_W-1:0] res;
        if (neg) begin
            if (mag > MW'(SAT_NEG_MAG)) res = SAT_NEG;
            else res = POINT_W'(0) - mag[POINT_W-1:0];
        end else begin
            if (mag > MW'(SAT_POS)) res = SAT_POS;
            else res = mag[POINT_W-1:0];
        end
        return res;
    endfunction

    logic [OUT_DATA_W-1:0] out_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {red_reg, green_reg, blue_reg, depth_reg,
                        sat_axis(neg_y_reg, mag_y_reg), sat_axis(neg_x_reg, mag_x_reg)};
        end
    end

endmodule
`default_nettype wire

>>> hdl/depth_pixel_backprojection.sv
// depth_pixel_backprojection: turns raster depth pixels into camera-frame points
// a skipped pixel is taken in the idle state alone; a kept pixel passes capture, two multiply
// steps, sum and output, set by the one-pixel-at-a-time sequence in dpb_ctrl
// a point reaches m_tdata through the multiply steps, the sum and the output step, which holds until the output is free
// the output register lets the next pixel enter while a point waits to be taken
// aresetn (synchronous, active low) restores default registers and zeroes row and column
`default_nettype none
module depth_pixel_backprojection #(
    parameter int PIXEL_STRIDE = 3,
    parameter int COORD_BITS   = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // depth_mm[15:0], blue[23:16], green[31:24], red[39:32]
    input  wire logic [dpb_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // point_x_mm[23:0], point_y_mm[47:24], point_z_mm[63:48],
    // point_blue[71:64], point_green[79:72], point_red[87:80]
    output logic      [dpb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dpb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dpb_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width     <= RST_IMAGE_WIDTH;
            cfg_reg.image_height    <= RST_IMAGE_HEIGHT;
            cfg_reg.center_x_q4     <= RST_CENTER_X_Q4;
            cfg_reg.center_y_q4     <= RST_CENTER_Y_Q4;
            cfg_reg.inv_focal_x_q24 <= RST_INV_FOCAL;
            cfg_reg.inv_focal_y_q24 <= RST_INV_FOCAL;
            cfg_reg.min_depth_mm    <= RST_MIN_DEPTH_MM;
            cfg_reg.max_depth_mm    <= RST_MAX_DEPTH_MM;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_wdata[DIM_W-1:0];
                REG_CENTER_X_Q4:     cfg_reg.center_x_q4     <= cfg_wdata[Q4_W-1:0];
                REG_CENTER_Y_Q4:     cfg_reg.center_y_q4     <= cfg_wdata[Q4_W-1:0];
                REG_INV_FOCAL_X_Q24: cfg_reg.inv_focal_x_q24 <= cfg_wdata[INV_W-1:0];
                REG_INV_FOCAL_Y_Q24: cfg_reg.inv_focal_y_q24 <= cfg_wdata[INV_W-1:0];
                REG_MIN_DEPTH_MM:    cfg_reg.min_depth_mm    <= cfg_wdata[DEPTH_W-1:0];
                REG_MAX_DEPTH_MM:    cfg_reg.max_depth_mm    <= cfg_wdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    dpb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpb_datapath #(
        .PIXEL_STRIDE (PIXEL_STRIDE),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg_reg),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire
